// ===== design/tlfd_pkg.sv =====
// ============================================================================
// tlfd_pkg
// Shared types, codes and the type byte decode for the frame deframer.
// ============================================================================
package tlfd_pkg;

    // Width of the frame length field and of the length limit register.
    localparam int LEN_W = 64;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2
    } out_kind_t;

    // Message codes.
    localparam logic [3:0] CODE_LOGIN      = 4'd0;
    localparam logic [3:0] CODE_LOGIN_RESP = 4'd1;
    localparam logic [3:0] CODE_NEW_PROXY  = 4'd2;
    localparam logic [3:0] CODE_PROXY_RESP = 4'd3;
    localparam logic [3:0] CODE_NEW_WORK   = 4'd4;
    localparam logic [3:0] CODE_REQ_WORK   = 4'd5;
    localparam logic [3:0] CODE_START_WORK = 4'd6;
    localparam logic [3:0] CODE_PING       = 4'd7;
    localparam logic [3:0] CODE_PONG       = 4'd8;
    localparam logic [3:0] CODE_UDP        = 4'd9;

    // Header byte counts: one type byte then eight length bytes.
    localparam logic [3:0] HDR_TYPE_POS = 4'd0;
    localparam logic [3:0] HDR_LAST_POS = 4'd8;

    // One result word.
    typedef struct packed {
        logic [3:0] msg_type;
        out_kind_t  out_kind;
        logic [7:0] data_byte;
        logic       last;
    } result_t;

    // Maps a type byte to its message code; unknown bytes become pong.
    function automatic logic [3:0] map_type(input logic [7:0] b);
        logic [3:0] code;
        unique case (b)
            8'h6f:   code = CODE_LOGIN;       // 'o'
            8'h31:   code = CODE_LOGIN_RESP;  // '1'
            8'h70:   code = CODE_NEW_PROXY;   // 'p'
            8'h32:   code = CODE_PROXY_RESP;  // '2'
            8'h77:   code = CODE_NEW_WORK;    // 'w'
            8'h72:   code = CODE_REQ_WORK;    // 'r'
            8'h73:   code = CODE_START_WORK;  // 's'
            8'h68:   code = CODE_PING;        // 'h'
            8'h34:   code = CODE_PONG;        // '4'
            8'h75:   code = CODE_UDP;         // 'u'
            default: code = CODE_PONG;
        endcase
        return code;
    endfunction

endpackage

// ===== design/tlfd_skid_buf.sv =====
// ============================================================================
// tlfd_skid_buf
// Two-entry output buffer: a result register plus a skid register, so the
// input side keeps flowing for one word while the output side stalls.
// ============================================================================
module tlfd_skid_buf
    import tlfd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Refill the output register from the skid first, else from the input.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_next       = in_data;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== design/type_length_frame_deframer_core.sv =====
// ============================================================================
// type_length_frame_deframer_core
// Splits a received byte stream into type/length/payload frames.
// ============================================================================
// Each frame is one type byte, an eight-byte big-endian length and then the
// payload. Every payload byte leaves as one word carrying its message code
// and a last mark; a zero-length frame gives one empty-message word, and a
// frame longer than max_len is swallowed and gives one oversize word on its
// final byte. The block takes one byte per clock cycle while its output
// buffer has room, and each result word is registered in the output buffer.
// The frame state update (a 64-bit decrement or a length shift with a
// 64-bit compare against max_len) is combinational. A two-word output
// buffer keeps input flowing for one word while the output side is stalled.
// max_len is sampled when the last length byte arrives.
module type_length_frame_deframer_core
    import tlfd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Configuration: max_len.
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    // Input words.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] rx_byte
    // Result words.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_byte
    output logic [5:0]       m_tuser,   // [1:0] out_kind, [5:2] msg_type
    output logic             m_tlast    // last
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DRAIN   = 3'b100
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       hdr_count_reg, hdr_count_next;
    logic [3:0]       type_code_reg, type_code_next;
    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic [LEN_W-1:0] max_len_reg;

    logic             accept;
    logic             res_valid;
    result_t          res;
    result_t          out_word;
    logic [LEN_W-1:0] len_shifted;
    logic             fin;

    assign accept      = s_tvalid && s_tready;
    assign len_shifted = {remaining_reg[LEN_W-9:0], s_tdata};
    assign fin         = (remaining_reg <= {{(LEN_W-1){1'b0}}, 1'b1});

    // Length limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LEN_W'(65536);
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Frame parser: next state and the result word for the current byte.
    always_comb begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        type_code_next = type_code_reg;
        remaining_next = remaining_reg;
        res_valid      = 1'b0;
        res.msg_type   = type_code_reg;
        res.out_kind   = KIND_DATA;
        res.data_byte  = 8'd0;
        res.last       = 1'b1;
        unique case (phase_reg)
            PH_PAYLOAD, PH_DRAIN: begin
                remaining_next = fin ? '0 : remaining_reg - 1'b1;
                if (fin) begin
                    phase_next = PH_HEADER;
                end
                if (phase_reg == PH_PAYLOAD) begin
                    res_valid     = 1'b1;
                    res.data_byte = s_tdata;
                    res.last      = fin;
                end else if (fin) begin
                    res_valid    = 1'b1;
                    res.out_kind = KIND_OVERSIZE;
                end
            end
            default: begin
                phase_next = PH_HEADER;
                if (hdr_count_reg == HDR_TYPE_POS) begin
                    type_code_next = map_type(s_tdata);
                    res.msg_type   = type_code_next;
                    remaining_next = '0;
                    hdr_count_next = 4'd1;
                end else begin
                    remaining_next = len_shifted;
                    if (hdr_count_reg < HDR_LAST_POS) begin
                        hdr_count_next = hdr_count_reg + 4'd1;
                    end else begin
                        hdr_count_next = HDR_TYPE_POS;
                        if (len_shifted == '0) begin
                            res_valid    = 1'b1;
                            res.out_kind = KIND_EMPTY;
                        end else if (len_shifted > max_len_reg) begin
                            phase_next = PH_DRAIN;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
        endcase
    end

    // Frame state registers, updated on each accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            hdr_count_reg <= HDR_TYPE_POS;
            type_code_reg <= CODE_LOGIN;
            remaining_reg <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            type_code_reg <= type_code_next;
            remaining_reg <= remaining_next;
        end
    end

    // Output buffering.
    tlfd_skid_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = out_word.data_byte;
    assign m_tuser = {out_word.msg_type, out_word.out_kind};
    assign m_tlast = out_word.last;

endmodule
